>>> sv/stl_pkg.sv
// ----------------------------------------------------------------------------
// stl_pkg
// Types, codes and character tables shared by the script token lexer.
// ----------------------------------------------------------------------------
package stl_pkg;

  typedef enum logic [3:0] {
    MODE_IDLE    = 4'd0,
    MODE_SLASH   = 4'd1,
    MODE_OP2     = 4'd2,
    MODE_IDENT   = 4'd3,
    MODE_ZERO    = 4'd4,
    MODE_OCT     = 4'd5,
    MODE_DEC     = 4'd6,
    MODE_HEX     = 4'd7,
    MODE_STR     = 4'd8,
    MODE_ESC     = 4'd9,
    MODE_HEX1    = 4'd10,
    MODE_HEX2    = 4'd11,
    MODE_COMMENT = 4'd12,
    MODE_ERR     = 4'd13
  } mode_e;

  typedef enum logic [3:0] {
    KIND_EOL     = 4'd0,
    KIND_IDENT   = 4'd1,
    KIND_INT     = 4'd2,
    KIND_STR     = 4'd3,
    KIND_DECLARE = 4'd4,
    KIND_TRUE    = 4'd5,
    KIND_FALSE   = 4'd6,
    KIND_AND     = 4'd7,
    KIND_OR      = 4'd8,
    KIND_EQ      = 4'd9,
    KIND_NE      = 4'd10,
    KIND_LE      = 4'd11,
    KIND_GE      = 4'd12,
    KIND_OP      = 4'd13,
    KIND_TEXT    = 4'd14,
    KIND_ERROR   = 4'd15
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_BAD_CHAR = 2'd1,
    ERR_TOO_LONG = 2'd2,
    ERR_ESCAPE   = 2'd3
  } err_e;

  typedef enum logic [1:0] {
    KW_NONE    = 2'd0,
    KW_DECLARE = 2'd1,
    KW_TRUE    = 2'd2,
    KW_FALSE   = 2'd3
  } kw_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  sym;
    logic [31:0] num;
    err_e        err;
    logic        last;
  } res_t;

  localparam int unsigned TdataW = 48;

  function automatic res_t mk_res(kind_e kind, logic [7:0] sym, logic [31:0] num, err_e err);
    res_t r;
    r.kind = kind;
    r.sym  = sym;
    r.num  = num;
    r.err  = err;
    r.last = 1'b0;
    return r;
  endfunction

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  function automatic hex_t hex_val(logic [7:0] c);
    hex_t h;
    h.ok  = 1'b1;
    h.val = 4'd0;
    if (c >= "0" && c <= "9") h.val = 4'(c - 8'h30);
    else if (c >= "a" && c <= "f") h.val = 4'(c - 8'h57);
    else if (c >= "A" && c <= "F") h.val = 4'(c - 8'h37);
    else h.ok = 1'b0;
    return h;
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_single_op(logic [7:0] c);
    return c == "+" || c == "-" || c == "*" || c == "^" || c == "[" || c == "]" ||
           c == "~" || c == ";" || c == "%" || c == "(" || c == ")" || c == "," ||
           c == ".";
  endfunction

  function automatic logic [7:0] kw_len(kw_e m);
    logic [7:0] n;
    unique case (m)
      KW_DECLARE: n = 8'd7;
      KW_TRUE:    n = 8'd4;
      KW_FALSE:   n = 8'd5;
      default:    n = 8'd0;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] kw_char(kw_e m, logic [2:0] idx);
    logic [7:0] ch;
    ch = 8'd0;
    unique case (m)
      KW_DECLARE: begin
        unique case (idx)
          3'd0: ch = "d";
          3'd1: ch = "e";
          3'd2: ch = "c";
          3'd3: ch = "l";
          3'd4: ch = "a";
          3'd5: ch = "r";
          3'd6: ch = "e";
          default: ch = 8'd0;
        endcase
      end
      KW_TRUE: begin
        unique case (idx)
          3'd0: ch = "t";
          3'd1: ch = "r";
          3'd2: ch = "u";
          3'd3: ch = "e";
          default: ch = 8'd0;
        endcase
      end
      KW_FALSE: begin
        unique case (idx)
          3'd0: ch = "f";
          3'd1: ch = "a";
          3'd2: ch = "l";
          3'd3: ch = "s";
          3'd4: ch = "e";
          default: ch = 8'd0;
        endcase
      end
      default: ch = 8'd0;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] esc_byte(logic [7:0] c);
    logic [7:0] b;
    unique case (c)
      "a":     b = 8'd7;
      "b":     b = 8'd8;
      "f":     b = 8'd12;
      "n":     b = 8'd10;
      "r":     b = 8'd13;
      "t":     b = 8'd9;
      "v":     b = 8'd11;
      default: b = c;
    endcase
    return b;
  endfunction

endpackage

>>> sv/stl_core.sv
// ----------------------------------------------------------------------------
// stl_core
// Lexer state and per-byte step logic: takes one byte when step_i is high
// and gives up to two tokens in the same cycle.
// ----------------------------------------------------------------------------
module stl_core #(
  parameter int unsigned MAX_IDENT    = 64,
  parameter int unsigned NUMBER_WIDTH = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  logic [7:0]    char_i,
  output logic [1:0]    res_cnt_o,
  output stl_pkg::res_t res0_o,
  output stl_pkg::res_t res1_o
);

  localparam int unsigned LenW = $clog2(MAX_IDENT + 1);
  localparam int unsigned NW   = NUMBER_WIDTH;

  stl_pkg::mode_e  mode_q, mode_d;
  logic [NW-1:0]   acc_q, acc_d;
  logic [LenW-1:0] len_q, len_d;
  stl_pkg::kw_e    kw_q, kw_d;
  logic [7:0]      pend_q, pend_d;
  logic [3:0]      nib_q, nib_d;

  // start of a new token from the idle mode
  stl_pkg::mode_e  st_mode;
  logic            st_emit;
  stl_pkg::res_t   st_res;
  logic            st_ident, st_zero, st_dec, st_op2;
  stl_pkg::kw_e    st_kw;

  logic [NW+31:0]  acc_ext;
  logic [31:0]     acc_num;
  logic [7:0]      len8;
  logic [3:0]      dig;
  stl_pkg::hex_t   hx;
  logic            run_st;
  logic [1:0]      cnt;
  stl_pkg::res_t   r0, r1, ra;
  stl_pkg::kind_e  id_kind;

  assign acc_ext = {32'd0, acc_q};
  assign acc_num = acc_ext[31:0];
  assign len8    = 8'(len_q);
  assign dig     = 4'(char_i - 8'h30);
  assign hx      = stl_pkg::hex_val(char_i);

  always_comb begin
    st_mode  = stl_pkg::MODE_IDLE;
    st_emit  = 1'b0;
    st_res   = stl_pkg::mk_res(stl_pkg::KIND_EOL, 8'd0, 32'd0, stl_pkg::ERR_NONE);
    st_ident = 1'b0;
    st_zero  = 1'b0;
    st_dec   = 1'b0;
    st_op2   = 1'b0;
    st_kw    = stl_pkg::KW_NONE;
    if (char_i == 8'd0) begin
      st_emit = 1'b1;
    end else if (stl_pkg::is_space(char_i)) begin
      st_mode = stl_pkg::MODE_IDLE;
    end else if (char_i == "/") begin
      st_mode = stl_pkg::MODE_SLASH;
    end else if (char_i == "\"") begin
      st_mode = stl_pkg::MODE_STR;
    end else if (stl_pkg::is_alpha(char_i) || char_i == "_") begin
      st_ident = 1'b1;
      st_mode  = stl_pkg::MODE_IDENT;
      st_emit  = 1'b1;
      st_res   = stl_pkg::mk_res(stl_pkg::KIND_TEXT, char_i, 32'd0, stl_pkg::ERR_NONE);
      if (char_i == "d") st_kw = stl_pkg::KW_DECLARE;
      else if (char_i == "t") st_kw = stl_pkg::KW_TRUE;
      else if (char_i == "f") st_kw = stl_pkg::KW_FALSE;
    end else if (char_i == "0") begin
      st_zero = 1'b1;
      st_mode = stl_pkg::MODE_ZERO;
    end else if (stl_pkg::is_digit(char_i)) begin
      st_dec  = 1'b1;
      st_mode = stl_pkg::MODE_DEC;
    end else if (char_i == "!" || char_i == "<" || char_i == ">" || char_i == "=" ||
                 char_i == "&" || char_i == "|") begin
      st_op2  = 1'b1;
      st_mode = stl_pkg::MODE_OP2;
    end else if (stl_pkg::is_single_op(char_i)) begin
      st_emit = 1'b1;
      st_res  = stl_pkg::mk_res(stl_pkg::KIND_OP, char_i, 32'd0, stl_pkg::ERR_NONE);
    end else begin
      st_emit = 1'b1;
      st_mode = stl_pkg::MODE_ERR;
      st_res  = stl_pkg::mk_res(stl_pkg::KIND_ERROR, 8'd0, 32'd0, stl_pkg::ERR_BAD_CHAR);
    end
  end

  always_comb begin
    mode_d  = mode_q;
    acc_d   = acc_q;
    len_d   = len_q;
    kw_d    = kw_q;
    pend_d  = pend_q;
    nib_d   = nib_q;
    run_st  = 1'b0;
    cnt     = 2'd0;
    ra      = stl_pkg::mk_res(stl_pkg::KIND_EOL, 8'd0, 32'd0, stl_pkg::ERR_NONE);
    r0      = ra;
    r1      = ra;
    id_kind = stl_pkg::KIND_IDENT;
    if (kw_q != stl_pkg::KW_NONE && len8 == stl_pkg::kw_len(kw_q)) begin
      unique case (kw_q)
        stl_pkg::KW_DECLARE: id_kind = stl_pkg::KIND_DECLARE;
        stl_pkg::KW_TRUE:    id_kind = stl_pkg::KIND_TRUE;
        default:             id_kind = stl_pkg::KIND_FALSE;
      endcase
    end

    unique case (mode_q)
      stl_pkg::MODE_SLASH: begin
        if (char_i == "/") begin
          mode_d = stl_pkg::MODE_COMMENT;
        end else begin
          cnt    = 2'd1;
          r0     = stl_pkg::mk_res(stl_pkg::KIND_OP, "/", 32'd0, stl_pkg::ERR_NONE);
          run_st = 1'b1;
        end
      end
      stl_pkg::MODE_OP2: begin
        cnt = 2'd1;
        if (char_i == "=" && pend_q == "!") begin
          r0     = stl_pkg::mk_res(stl_pkg::KIND_NE, 8'd0, 32'd0, stl_pkg::ERR_NONE);
          mode_d = stl_pkg::MODE_IDLE;
        end else if (char_i == "=" && pend_q == "<") begin
          r0     = stl_pkg::mk_res(stl_pkg::KIND_LE, 8'd0, 32'd0, stl_pkg::ERR_NONE);
          mode_d = stl_pkg::MODE_IDLE;
        end else if (char_i == "=" && pend_q == ">") begin
          r0     = stl_pkg::mk_res(stl_pkg::KIND_GE, 8'd0, 32'd0, stl_pkg::ERR_NONE);
          mode_d = stl_pkg::MODE_IDLE;
        end else if (char_i == "=" && pend_q == "=") begin
          r0     = stl_pkg::mk_res(stl_pkg::KIND_EQ, 8'd0, 32'd0, stl_pkg::ERR_NONE);
          mode_d = stl_pkg::MODE_IDLE;
        end else if (char_i == "&" && pend_q == "&") begin
          r0     = stl_pkg::mk_res(stl_pkg::KIND_AND, 8'd0, 32'd0, stl_pkg::ERR_NONE);
          mode_d = stl_pkg::MODE_IDLE;
        end else if (char_i == "|" && pend_q == "|") begin
          r0     = stl_pkg::mk_res(stl_pkg::KIND_OR, 8'd0, 32'd0, stl_pkg::ERR_NONE);
          mode_d = stl_pkg::MODE_IDLE;
        end else begin
          r0     = stl_pkg::mk_res(stl_pkg::KIND_OP, pend_q, 32'd0, stl_pkg::ERR_NONE);
          run_st = 1'b1;
        end
      end
      stl_pkg::MODE_IDENT: begin
        cnt = 2'd1;
        if (stl_pkg::is_alpha(char_i) || stl_pkg::is_digit(char_i) || char_i == "_") begin
          if (len_q >= LenW'(MAX_IDENT)) begin
            r0     = stl_pkg::mk_res(stl_pkg::KIND_ERROR, 8'd0, 32'd0,
                                     stl_pkg::ERR_TOO_LONG);
            mode_d = stl_pkg::MODE_ERR;
          end else begin
            if (kw_q != stl_pkg::KW_NONE &&
                (len8 >= stl_pkg::kw_len(kw_q) ||
                 stl_pkg::kw_char(kw_q, len8[2:0]) != char_i)) begin
              kw_d = stl_pkg::KW_NONE;
            end
            len_d = len_q + LenW'(1);
            r0    = stl_pkg::mk_res(stl_pkg::KIND_TEXT, char_i, 32'd0, stl_pkg::ERR_NONE);
          end
        end else begin
          r0     = stl_pkg::mk_res(id_kind, 8'd0, 32'd0, stl_pkg::ERR_NONE);
          run_st = 1'b1;
        end
      end
      stl_pkg::MODE_ZERO, stl_pkg::MODE_OCT: begin
        if (mode_q == stl_pkg::MODE_ZERO && char_i == "x") begin
          acc_d  = '0;
          mode_d = stl_pkg::MODE_HEX;
        end else if (char_i >= "0" && char_i <= "7") begin
          acc_d  = (acc_q << 3) + NW'(dig);
          mode_d = stl_pkg::MODE_OCT;
        end else begin
          cnt    = 2'd1;
          r0     = stl_pkg::mk_res(stl_pkg::KIND_INT, 8'd0, acc_num, stl_pkg::ERR_NONE);
          run_st = 1'b1;
        end
      end
      stl_pkg::MODE_DEC: begin
        if (stl_pkg::is_digit(char_i)) begin
          acc_d = (acc_q << 3) + (acc_q << 1) + NW'(dig);
        end else begin
          cnt    = 2'd1;
          r0     = stl_pkg::mk_res(stl_pkg::KIND_INT, 8'd0, acc_num, stl_pkg::ERR_NONE);
          run_st = 1'b1;
        end
      end
      stl_pkg::MODE_HEX: begin
        if (hx.ok) begin
          acc_d = (acc_q << 4) + NW'(hx.val);
        end else begin
          cnt    = 2'd1;
          r0     = stl_pkg::mk_res(stl_pkg::KIND_INT, 8'd0, acc_num, stl_pkg::ERR_NONE);
          run_st = 1'b1;
        end
      end
      stl_pkg::MODE_STR: begin
        if (char_i == 8'd0) begin
          cnt    = 2'd2;
          r0     = stl_pkg::mk_res(stl_pkg::KIND_STR, 8'd0, 32'd0, stl_pkg::ERR_NONE);
          mode_d = stl_pkg::MODE_IDLE;
        end else if (char_i == "\"") begin
          cnt    = 2'd1;
          r0     = stl_pkg::mk_res(stl_pkg::KIND_STR, 8'd0, 32'd0, stl_pkg::ERR_NONE);
          mode_d = stl_pkg::MODE_IDLE;
        end else if (char_i == "\\") begin
          mode_d = stl_pkg::MODE_ESC;
        end else begin
          cnt = 2'd1;
          r0  = stl_pkg::mk_res(stl_pkg::KIND_TEXT, char_i, 32'd0, stl_pkg::ERR_NONE);
        end
      end
      stl_pkg::MODE_ESC: begin
        if (char_i == 8'd0) begin
          cnt    = 2'd2;
          r0     = stl_pkg::mk_res(stl_pkg::KIND_ERROR, 8'd0, 32'd0, stl_pkg::ERR_ESCAPE);
          mode_d = stl_pkg::MODE_IDLE;
        end else if (char_i == "x") begin
          mode_d = stl_pkg::MODE_HEX1;
        end else begin
          cnt    = 2'd1;
          r0     = stl_pkg::mk_res(stl_pkg::KIND_TEXT, stl_pkg::esc_byte(char_i), 32'd0,
                                   stl_pkg::ERR_NONE);
          mode_d = stl_pkg::MODE_STR;
        end
      end
      stl_pkg::MODE_HEX1, stl_pkg::MODE_HEX2: begin
        cnt = 2'd1;
        if (hx.ok && mode_q == stl_pkg::MODE_HEX1) begin
          cnt    = 2'd0;
          nib_d  = hx.val;
          mode_d = stl_pkg::MODE_HEX2;
        end else if (hx.ok) begin
          r0     = stl_pkg::mk_res(stl_pkg::KIND_TEXT, {nib_q, hx.val}, 32'd0,
                                   stl_pkg::ERR_NONE);
          mode_d = stl_pkg::MODE_STR;
        end else begin
          r0 = stl_pkg::mk_res(stl_pkg::KIND_ERROR, 8'd0, 32'd0, stl_pkg::ERR_ESCAPE);
          if (char_i == 8'd0) begin
            cnt    = 2'd2;
            mode_d = stl_pkg::MODE_IDLE;
          end else begin
            mode_d = stl_pkg::MODE_ERR;
          end
        end
      end
      stl_pkg::MODE_COMMENT, stl_pkg::MODE_ERR: begin
        if (char_i == 8'd0) begin
          cnt    = 2'd1;
          r0     = ra;
          mode_d = stl_pkg::MODE_IDLE;
        end
      end
      default: begin
        run_st = 1'b1;
      end
    endcase

    if (run_st) begin
      mode_d = st_mode;
      if (st_ident) begin
        len_d = LenW'(1);
        kw_d  = st_kw;
      end
      if (st_zero) acc_d = '0;
      if (st_dec) acc_d = NW'(dig);
      if (st_op2) pend_d = char_i;
      if (st_emit) begin
        if (cnt == 2'd0) r0 = st_res;
        else r1 = st_res;
        cnt = cnt + 2'd1;
      end
    end

    if (cnt == 2'd2) r1.last = 1'b1;
    else r0.last = 1'b1;
  end

  assign res_cnt_o = cnt;
  assign res0_o    = r0;
  assign res1_o    = r1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= stl_pkg::MODE_IDLE;
      acc_q  <= '0;
      len_q  <= '0;
      kw_q   <= stl_pkg::KW_NONE;
      pend_q <= 8'd0;
      nib_q  <= 4'd0;
    end else if (step_i) begin
      mode_q <= mode_d;
      acc_q  <= acc_d;
      len_q  <= len_d;
      kw_q   <= kw_d;
      pend_q <= pend_d;
      nib_q  <= nib_d;
    end
  end

endmodule

>>> sv/script_token_lexer.sv
// ----------------------------------------------------------------------------
// script_token_lexer
// Streaming lexer for C-style script lines: one byte in, zero to two tokens
// out, with a byte register in front and a four-entry token queue behind.
//
//   channel   dir  tdata                                    tuser       tlast
//   s_axis    in   char_code[7:0]                           -           -
//   m_axis    out  symbol[7:0] number[39:8] error_code[41:40] token_kind  last
//
// a byte is lexed from the byte register once the queue has room for two tokens,
// one byte per cycle while it has; a byte giving two tokens holds the output for
// two beats; the token queue's free space gates the lexer step
// reset returns to idle between tokens with an empty queue
// either side may stall at any time without loss
// ----------------------------------------------------------------------------
module script_token_lexer #(
  parameter int unsigned MAX_IDENT    = 64,
  parameter int unsigned NUMBER_WIDTH = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [7:0]                 s_axis_tdata,   // char_code
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [stl_pkg::TdataW-1:0] m_axis_tdata,   // symbol, number, error_code
  output logic [3:0]                 m_axis_tuser,   // token_kind
  output logic                       m_axis_tlast
);

  logic          in_vld_q;
  logic [7:0]    in_char_q;
  logic          step;
  logic          pop;
  logic [1:0]    res_cnt;
  stl_pkg::res_t res0, res1;
  stl_pkg::res_t fifo_q [4];
  logic [1:0]    wr_ptr_q, rd_ptr_q;
  logic [2:0]    cnt_q;
  logic [1:0]    push_n;
  stl_pkg::res_t head;

  assign step          = in_vld_q && (cnt_q <= 3'd2);
  assign s_axis_tready = !in_vld_q || step;
  assign push_n        = step ? res_cnt : 2'd0;
  assign pop           = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_vld_q <= 1'b1;
    end else if (step) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_char_q <= s_axis_tdata;
    end
  end

  stl_core #(
    .MAX_IDENT    (MAX_IDENT),
    .NUMBER_WIDTH (NUMBER_WIDTH)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .char_i    (in_char_q),
    .res_cnt_o (res_cnt),
    .res0_o    (res0),
    .res1_o    (res1)
  );

  // token queue
  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) fifo_q[wr_ptr_q] <= res0;
    if (push_n == 2'd2) fifo_q[wr_ptr_q + 2'd1] <= res1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 2'd0;
      rd_ptr_q <= 2'd0;
      cnt_q    <= 3'd0;
    end else begin
      wr_ptr_q <= wr_ptr_q + push_n;
      rd_ptr_q <= rd_ptr_q + {1'b0, pop};
      cnt_q    <= cnt_q + {1'b0, push_n} - {2'b00, pop};
    end
  end

  assign head          = fifo_q[rd_ptr_q];
  assign m_axis_tvalid = cnt_q != 3'd0;
  assign m_axis_tdata  = {6'd0, head.err, head.num, head.sym};
  assign m_axis_tuser  = head.kind;
  assign m_axis_tlast  = head.last;

endmodule

>>> sim/lexer_token_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lexer_token_checker
// Watches both stream channels of the script token lexer. Every byte taken
// on the input runs through a bit-exact lexer model kept here. The model
// queues the tokens that the byte must produce. Every token beat on the
// output is then compared field by field with the oldest queued token.
// ----------------------------------------------------------------------------
module lexer_token_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_tvalid_i,
  input  logic                        s_tready_i,
  input  logic [7:0]                  s_tdata_i,
  input  logic                        m_tvalid_i,
  input  logic                        m_tready_i,
  input  logic [stl_pkg::TdataW-1:0]  m_tdata_i,
  input  logic [3:0]                  m_tuser_i,
  input  logic                        m_tlast_i,
  output int                          fail_count_o,
  output int                          pending_o,
  output int                          chars_o,
  output int                          beats_o,
  output int                          err_tokens_o
);

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam int         IDENT_MAX = 64;

  typedef struct packed {
    stl_pkg::kind_e kind;
    logic [7:0]     sym;
    logic [31:0]    num;
    stl_pkg::err_e  err;
    logic           last;
  } token_t;

  token_t         token_q[$];
  token_t         step_tok[2];
  int             step_n;

  stl_pkg::mode_e lx_mode;
  logic [31:0]    acc;
  logic [6:0]     id_len;
  stl_pkg::kw_e   kw;
  logic [7:0]     op_first;
  logic [3:0]     esc_hi;

  int             fail_cnt;
  int             char_cnt;
  int             beat_cnt;
  int             err_cnt;

  function automatic logic letter(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic int nib_of(logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c) - 48;
    if (c >= "a" && c <= "f") return int'(c) - 87;
    if (c >= "A" && c <= "F") return int'(c) - 55;
    return -1;
  endfunction

  function automatic logic one_char_op(logic [7:0] c);
    return c == "+" || c == "-" || c == "*" || c == "^" || c == "[" || c == "]" ||
           c == "~" || c == ";" || c == "%" || c == "(" || c == ")" || c == "," ||
           c == ".";
  endfunction

  function automatic int kw_size(stl_pkg::kw_e m);
    case (m)
      stl_pkg::KW_DECLARE: return 7;
      stl_pkg::KW_TRUE:    return 4;
      stl_pkg::KW_FALSE:   return 5;
      default:             return 0;
    endcase
  endfunction

  function automatic logic [7:0] kw_letter(stl_pkg::kw_e m, logic [6:0] idx);
    logic [55:0] word;
    int          n;
    word = '0;
    n    = kw_size(m);
    case (m)
      stl_pkg::KW_DECLARE: word = "declare";
      stl_pkg::KW_TRUE:    word = "true";
      stl_pkg::KW_FALSE:   word = "false";
      default:             word = '0;
    endcase
    if (int'(idx) >= n) return 8'd0;
    return word[(n - 1 - int'(idx)) * 8 +: 8];
  endfunction

  function automatic logic [7:0] esc_decode(logic [7:0] c);
    case (c)
      "a":     return 8'd7;
      "b":     return 8'd8;
      "f":     return 8'd12;
      "n":     return 8'd10;
      "r":     return 8'd13;
      "t":     return 8'd9;
      "v":     return 8'd11;
      default: return c;
    endcase
  endfunction

  task automatic put_tok(input stl_pkg::kind_e k, input logic [7:0] s,
                         input logic [31:0] n, input stl_pkg::err_e e);
    if (step_n < 2) begin
      step_tok[step_n].kind = k;
      step_tok[step_n].sym  = s;
      step_tok[step_n].num  = n;
      step_tok[step_n].err  = e;
      step_tok[step_n].last = 1'b0;
      step_n++;
    end
  endtask

  task automatic lex_error(input stl_pkg::err_e e, input logic [7:0] c);
    put_tok(stl_pkg::KIND_ERROR, 8'd0, 32'd0, e);
    if (c == 8'd0) begin
      put_tok(stl_pkg::KIND_EOL, 8'd0, 32'd0, stl_pkg::ERR_NONE);
      lx_mode = stl_pkg::MODE_IDLE;
    end else begin
      lx_mode = stl_pkg::MODE_ERR;
    end
  endtask

  task automatic open_token(input logic [7:0] c);
    lx_mode = stl_pkg::MODE_IDLE;
    if (c == 8'd0) begin
      put_tok(stl_pkg::KIND_EOL, 8'd0, 32'd0, stl_pkg::ERR_NONE);
    end else if (c == " " || (c >= 8'd9 && c <= 8'd13)) begin
      lx_mode = stl_pkg::MODE_IDLE;
    end else if (c == "/") begin
      lx_mode = stl_pkg::MODE_SLASH;
    end else if (c == CH_QUOTE) begin
      lx_mode = stl_pkg::MODE_STR;
    end else if (letter(c) || c == "_") begin
      id_len  = 7'd1;
      kw      = (c == "d") ? stl_pkg::KW_DECLARE : (c == "t") ? stl_pkg::KW_TRUE :
                (c == "f") ? stl_pkg::KW_FALSE : stl_pkg::KW_NONE;
      put_tok(stl_pkg::KIND_TEXT, c, 32'd0, stl_pkg::ERR_NONE);
      lx_mode = stl_pkg::MODE_IDENT;
    end else if (c == "0") begin
      acc     = '0;
      lx_mode = stl_pkg::MODE_ZERO;
    end else if (digit(c)) begin
      acc     = 32'(c - 8'h30);
      lx_mode = stl_pkg::MODE_DEC;
    end else if (c == "!" || c == "<" || c == ">" || c == "=" || c == "&" || c == "|") begin
      op_first = c;
      lx_mode  = stl_pkg::MODE_OP2;
    end else if (one_char_op(c)) begin
      put_tok(stl_pkg::KIND_OP, c, 32'd0, stl_pkg::ERR_NONE);
    end else begin
      lex_error(stl_pkg::ERR_BAD_CHAR, c);
    end
  endtask

  task automatic end_num(input logic [7:0] c);
    put_tok(stl_pkg::KIND_INT, 8'd0, acc, stl_pkg::ERR_NONE);
    open_token(c);
  endtask

  task automatic octal_byte(input logic [7:0] c);
    if (c >= "0" && c <= "7") acc = acc * 32'd8 + 32'(c - 8'h30);
    else end_num(c);
  endtask

  // runs one byte through the lexer and queues what it yields
  task automatic lex_byte(input logic [7:0] c);
    int             h;
    stl_pkg::kind_e k2;
    logic           matched;
    step_n  = 0;
    h       = nib_of(c);
    k2      = stl_pkg::KIND_IDENT;
    matched = 1'b1;
    case (lx_mode)
      stl_pkg::MODE_SLASH: begin
        if (c == "/") begin
          lx_mode = stl_pkg::MODE_COMMENT;
        end else begin
          put_tok(stl_pkg::KIND_OP, "/", 32'd0, stl_pkg::ERR_NONE);
          open_token(c);
        end
      end
      stl_pkg::MODE_OP2: begin
        if (c == "=" && op_first == "!") k2 = stl_pkg::KIND_NE;
        else if (c == "=" && op_first == "<") k2 = stl_pkg::KIND_LE;
        else if (c == "=" && op_first == ">") k2 = stl_pkg::KIND_GE;
        else if (c == "=" && op_first == "=") k2 = stl_pkg::KIND_EQ;
        else if (c == "&" && op_first == "&") k2 = stl_pkg::KIND_AND;
        else if (c == "|" && op_first == "|") k2 = stl_pkg::KIND_OR;
        else matched = 1'b0;
        if (matched) begin
          put_tok(k2, 8'd0, 32'd0, stl_pkg::ERR_NONE);
          lx_mode = stl_pkg::MODE_IDLE;
        end else begin
          put_tok(stl_pkg::KIND_OP, op_first, 32'd0, stl_pkg::ERR_NONE);
          open_token(c);
        end
      end
      stl_pkg::MODE_IDENT: begin
        if (letter(c) || digit(c) || c == "_") begin
          if (int'(id_len) >= IDENT_MAX) begin
            lex_error(stl_pkg::ERR_TOO_LONG, c);
          end else begin
            if (kw != stl_pkg::KW_NONE) begin
              if (int'(id_len) >= kw_size(kw) || kw_letter(kw, id_len) != c)
                kw = stl_pkg::KW_NONE;
            end
            id_len = id_len + 7'd1;
            put_tok(stl_pkg::KIND_TEXT, c, 32'd0, stl_pkg::ERR_NONE);
          end
        end else begin
          if (kw != stl_pkg::KW_NONE && int'(id_len) == kw_size(kw)) begin
            k2 = (kw == stl_pkg::KW_DECLARE) ? stl_pkg::KIND_DECLARE :
                 (kw == stl_pkg::KW_TRUE) ? stl_pkg::KIND_TRUE : stl_pkg::KIND_FALSE;
          end
          put_tok(k2, 8'd0, 32'd0, stl_pkg::ERR_NONE);
          open_token(c);
        end
      end
      stl_pkg::MODE_ZERO: begin
        if (c == "x") begin
          acc     = '0;
          lx_mode = stl_pkg::MODE_HEX;
        end else begin
          lx_mode = stl_pkg::MODE_OCT;
          octal_byte(c);
        end
      end
      stl_pkg::MODE_OCT: octal_byte(c);
      stl_pkg::MODE_DEC: begin
        if (digit(c)) acc = acc * 32'd10 + 32'(c - 8'h30);
        else end_num(c);
      end
      stl_pkg::MODE_HEX: begin
        if (h >= 0) acc = acc * 32'd16 + 32'(h);
        else end_num(c);
      end
      stl_pkg::MODE_STR: begin
        if (c == 8'd0) begin
          put_tok(stl_pkg::KIND_STR, 8'd0, 32'd0, stl_pkg::ERR_NONE);
          put_tok(stl_pkg::KIND_EOL, 8'd0, 32'd0, stl_pkg::ERR_NONE);
          lx_mode = stl_pkg::MODE_IDLE;
        end else if (c == CH_QUOTE) begin
          put_tok(stl_pkg::KIND_STR, 8'd0, 32'd0, stl_pkg::ERR_NONE);
          lx_mode = stl_pkg::MODE_IDLE;
        end else if (c == CH_BSLASH) begin
          lx_mode = stl_pkg::MODE_ESC;
        end else begin
          put_tok(stl_pkg::KIND_TEXT, c, 32'd0, stl_pkg::ERR_NONE);
        end
      end
      stl_pkg::MODE_ESC: begin
        if (c == 8'd0) begin
          lex_error(stl_pkg::ERR_ESCAPE, c);
        end else if (c == "x") begin
          lx_mode = stl_pkg::MODE_HEX1;
        end else begin
          put_tok(stl_pkg::KIND_TEXT, esc_decode(c), 32'd0, stl_pkg::ERR_NONE);
          lx_mode = stl_pkg::MODE_STR;
        end
      end
      stl_pkg::MODE_HEX1: begin
        if (h >= 0) begin
          esc_hi  = h[3:0];
          lx_mode = stl_pkg::MODE_HEX2;
        end else begin
          lex_error(stl_pkg::ERR_ESCAPE, c);
        end
      end
      stl_pkg::MODE_HEX2: begin
        if (h >= 0) begin
          put_tok(stl_pkg::KIND_TEXT, {esc_hi, h[3:0]}, 32'd0, stl_pkg::ERR_NONE);
          lx_mode = stl_pkg::MODE_STR;
        end else begin
          lex_error(stl_pkg::ERR_ESCAPE, c);
        end
      end
      stl_pkg::MODE_COMMENT, stl_pkg::MODE_ERR: begin
        if (c == 8'd0) begin
          put_tok(stl_pkg::KIND_EOL, 8'd0, 32'd0, stl_pkg::ERR_NONE);
          lx_mode = stl_pkg::MODE_IDLE;
        end
      end
      default: open_token(c);
    endcase
    if (step_n > 0) step_tok[step_n - 1].last = 1'b1;
    for (int i = 0; i < step_n; i++) token_q.push_back(step_tok[i]);
  endtask

  task automatic check_beat();
    token_t want;
    beat_cnt++;
    if (token_q.size() == 0) begin
      fail_cnt++;
      $display("%0t unexpected token beat: expected none, got kind %0d tdata %012h last %0b",
               $time, m_tuser_i, m_tdata_i, m_tlast_i);
    end else begin
      want = token_q.pop_front();
      if (want.kind == stl_pkg::KIND_ERROR) err_cnt++;
      if (m_tuser_i !== want.kind || m_tdata_i[7:0] !== want.sym ||
          m_tdata_i[39:8] !== want.num || m_tdata_i[41:40] !== want.err ||
          m_tdata_i[stl_pkg::TdataW-1:42] !== '0 || m_tlast_i !== want.last) begin
        fail_cnt++;
        $display("%0t token mismatch: expected kind %0d sym %02h num %08h err %0d last %0b",
                 $time, want.kind, want.sym, want.num, want.err, want.last);
        $display("%0t   got kind %0d sym %02h num %08h err %0d pad %02h last %0b",
                 $time, m_tuser_i, m_tdata_i[7:0], m_tdata_i[39:8], m_tdata_i[41:40],
                 m_tdata_i[stl_pkg::TdataW-1:42], m_tlast_i);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lx_mode  = stl_pkg::MODE_IDLE;
      acc      = '0;
      id_len   = '0;
      kw       = stl_pkg::KW_NONE;
      op_first = '0;
      esc_hi   = '0;
      step_n   = 0;
      token_q.delete();
      fail_cnt = 0;
      char_cnt = 0;
      beat_cnt = 0;
      err_cnt  = 0;
    end else begin
      if (s_tvalid_i && s_tready_i) begin
        lex_byte(s_tdata_i);
        char_cnt++;
      end
      if (m_tvalid_i && m_tready_i) check_beat();
    end
    fail_count_o <= fail_cnt;
    pending_o    <= token_q.size();
    chars_o      <= char_cnt;
    beats_o      <= beat_cnt;
    err_tokens_o <= err_cnt;
  end

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the script token lexer. A short directed line set
// comes first. Random script lines follow, built mostly from well-formed
// tokens with random content and mixed with noise. Both stream sides idle at
// random. One long output hold-off forces back-pressure onto the input.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int RANDOM_CHARS = 600;
  localparam int HOLD_CYCLES  = 200;
  localparam int STUCK_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 20;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       s_tvalid;
  logic                       s_tready;
  logic [7:0]                 s_tdata;
  logic                       m_tvalid;
  logic                       m_tready;
  logic [stl_pkg::TdataW-1:0] m_tdata;
  logic [3:0]                 m_tuser;
  logic                       m_tlast;

  int fail_count;
  int pending;
  int chars_seen;
  int beats_seen;
  int err_tokens;

  logic [7:0] char_q[$];
  bit         tx_idle;
  bit         rx_idle;
  bit         hold_req;
  int         stuck_cycles;
  int         line_count;

  script_token_lexer u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tuser  (m_tuser),
    .m_axis_tlast  (m_tlast)
  );

  lexer_token_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_tvalid),
    .s_tready_i   (s_tready),
    .s_tdata_i    (s_tdata),
    .m_tvalid_i   (m_tvalid),
    .m_tready_i   (m_tready),
    .m_tdata_i    (m_tdata),
    .m_tuser_i    (m_tuser),
    .m_tlast_i    (m_tlast),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .chars_o      (chars_seen),
    .beats_o      (beats_seen),
    .err_tokens_o (err_tokens)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (!rst_ni || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // output side: random stalls plus one long hold-off on request
  initial begin : rx_drive
    int k;
    m_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready = 1'b0;
        for (k = 0; k < HOLD_CYCLES; k++) @(negedge clk_i);
      end
      m_tready = !rx_idle || ($urandom_range(99) >= 22);
    end
  end

  function automatic logic [7:0] pick_char(input string set);
    return set[$urandom_range(set.len() - 1)];
  endfunction

  function automatic logic [7:0] head_char();
    if ($urandom_range(99) < 30) return pick_char("dtf");
    return pick_char("abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_");
  endfunction

  function automatic logic [7:0] tail_char();
    return pick_char("abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789");
  endfunction

  function automatic logic [7:0] hex_char();
    return pick_char("0123456789abcdefABCDEF");
  endfunction

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) char_q.push_back(s[i]);
  endtask

  task automatic add_ident(input int n);
    char_q.push_back(head_char());
    for (int i = 1; i < n; i++) char_q.push_back(tail_char());
  endtask

  // exact keywords and near misses around them
  task automatic add_keyword();
    string w;
    int    v;
    int    pos;
    case ($urandom_range(2))
      0:       w = "declare";
      1:       w = "true";
      default: w = "false";
    endcase
    v = $urandom_range(9);
    if (v == 7) begin
      w = w.substr(0, w.len() - 2);
    end else if (v == 9) begin
      pos    = $urandom_range(1, w.len() - 1);
      w[pos] = tail_char();
    end
    add_text(w);
    if (v == 8) char_q.push_back(tail_char());
  endtask

  task automatic add_dec();
    int n;
    n = $urandom_range(1, 12);
    char_q.push_back(8'h31 + 8'($urandom_range(8)));
    for (int i = 1; i < n; i++) char_q.push_back(8'h30 + 8'($urandom_range(9)));
  endtask

  task automatic add_oct();
    int n;
    n = $urandom_range(0, 11);
    char_q.push_back("0");
    for (int i = 0; i < n; i++) char_q.push_back(8'h30 + 8'($urandom_range(7)));
    if ($urandom_range(9) == 0) char_q.push_back(pick_char("89"));
  endtask

  task automatic add_hex();
    int n;
    n = $urandom_range(0, 9);
    add_text("0x");
    for (int i = 0; i < n; i++) char_q.push_back(hex_char());
  endtask

  task automatic add_string(output bit open);
    int         k;
    int         r;
    logic [7:0] c;
    char_q.push_back(CH_QUOTE);
    k = $urandom_range(0, 8);
    for (int i = 0; i < k; i++) begin
      r = $urandom_range(99);
      if (r < 55) begin
        c = 8'($urandom_range(32, 126));
        if (c == CH_QUOTE || c == CH_BSLASH) c = "s";
        char_q.push_back(c);
      end else if (r < 63) begin
        char_q.push_back(8'($urandom_range(128, 255)));
      end else if (r < 83) begin
        char_q.push_back(CH_BSLASH);
        char_q.push_back(pick_char("abfnrtvq0?\\\""));
      end else if (r < 95) begin
        char_q.push_back(CH_BSLASH);
        char_q.push_back("x");
        char_q.push_back(hex_char());
        char_q.push_back(hex_char());
      end else begin
        char_q.push_back(CH_BSLASH);
        char_q.push_back("x");
        if ($urandom_range(1)) char_q.push_back(hex_char());
        char_q.push_back(pick_char("gGz -"));
      end
    end
    open = ($urandom_range(99) < 12);
    if (!open) char_q.push_back(CH_QUOTE);
    else if ($urandom_range(1)) char_q.push_back(CH_BSLASH);
  endtask

  task automatic add_op();
    if ($urandom_range(1)) begin
      char_q.push_back(pick_char("+-*^[]~;%(),./!<>=&|"));
    end else begin
      case ($urandom_range(8))
        0:       add_text("&&");
        1:       add_text("||");
        2:       add_text("==");
        3:       add_text("!=");
        4:       add_text("<=");
        5:       add_text(">=");
        6:       add_text("=<");
        7:       add_text("&|");
        default: add_text("!!");
      endcase
    end
  endtask

  task automatic add_comment();
    int n;
    n = $urandom_range(0, 6);
    add_text("//");
    for (int i = 0; i < n; i++) char_q.push_back(8'($urandom_range(1, 255)));
  endtask

  task automatic build_line();
    int ntok;
    int pick;
    int r;
    bit stop;
    stop = 1'b0;
    ntok = $urandom_range(1, 8);
    for (int i = 0; i < ntok && !stop; i++) begin
      pick = $urandom_range(99);
      if (pick < 18) add_ident($urandom_range(1, 8));
      else if (pick < 20) add_ident($urandom_range(62, 66));
      else if (pick < 31) add_keyword();
      else if (pick < 40) add_dec();
      else if (pick < 46) add_oct();
      else if (pick < 53) add_hex();
      else if (pick < 66) add_string(stop);
      else if (pick < 84) add_op();
      else if (pick < 88) begin
        add_comment();
        stop = 1'b1;
      end else char_q.push_back(8'($urandom_range(1, 255)));
      if (!stop) begin
        r = $urandom_range(99);
        if (r < 55) char_q.push_back(" ");
        else if (r < 65) char_q.push_back(8'($urandom_range(9, 13)));
      end
    end
    char_q.push_back(8'd0);
  endtask

  task automatic send_char(input logic [7:0] c);
    while (tx_idle && $urandom_range(99) < 22) begin
      s_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_tvalid = 1'b1;
    s_tdata  = c;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_line();
    while (char_q.size() > 0) send_char(char_q.pop_front());
    line_count++;
  endtask

  initial begin : stimulus
    int  random_sent;
    bit  hold_done;
    random_sent  = 0;
    hold_done    = 1'b0;
    line_count   = 0;
    tx_idle      = 1'b1;
    rx_idle      = 1'b1;
    hold_req     = 1'b0;
    s_tvalid     = 1'b0;
    s_tdata      = 8'd0;
    rst_ni       = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // keyword, not-equal, octal cut by 8, lone slash, ident cut by a bad byte
    add_text("true !=078/a");
    char_q.push_back(8'hff);
    char_q.push_back(8'd0);
    send_line();
    // line ends inside a hex escape, then right after a backslash
    char_q.push_back(CH_QUOTE);
    add_text("\\x");
    char_q.push_back(8'd0);
    send_line();
    char_q.push_back(CH_QUOTE);
    char_q.push_back(CH_BSLASH);
    char_q.push_back(8'd0);
    send_line();
    add_text("//");
    char_q.push_back(8'd0);
    send_line();

    while (random_sent < RANDOM_CHARS) begin
      if (random_sent >= 200 && !hold_done) begin
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end
      tx_idle = !(random_sent >= 300 && random_sent < 450);
      rx_idle = tx_idle;
      build_line();
      random_sent += char_q.size();
      send_line();
    end
    s_tvalid = 1'b0;
    tx_idle  = 1'b1;
    rx_idle  = 1'b1;

    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("lexed %0d chars over %0d lines into %0d token beats, %0d of them errors",
             chars_seen, line_count, beats_seen, err_tokens);
    $display("random stalls on both sides, one %0d-cycle output hold-off", HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
